// ===== sv/chc_pkg.sv =====
`timescale 1ns / 1ps

package chc_pkg;

   // Field and datapath widths
   localparam int AXIS_W  = 16;
   localparam int ROW_W   = 48;
   localparam int HEAD_W  = 15;
   localparam int DIFF_W  = 17;  // raw minus offset, exact
   localparam int PROD_W  = 33;  // Q2.14 coefficient times difference
   localparam int ACC_W   = 35;  // sum of three products plus rounding term
   localparam int V_W     = 20;  // rounded, unsaturated calibrated axis
   localparam int COORD_W = 24;  // CORDIC x/y with gain and headroom
   localparam int ANGLE_W = 25;  // CORDIC angle, 1/16384 degree
   localparam int FRAC_W  = 14;
   localparam int TABLE_LEN = 24;

   localparam logic signed [ACC_W-1:0]   ROUND_HALF = ACC_W'(8192);
   localparam logic signed [ANGLE_W-1:0] ANGLE_FULL = ANGLE_W'(5898240);
   localparam logic signed [ANGLE_W-1:0] ANGLE_HALF = ANGLE_W'(2949120);
   localparam logic [HEAD_W-1:0]         HEAD_WRAP  = HEAD_W'(23040);
   localparam logic [22:0]               HEAD_ROUND = 23'd128;

   localparam logic signed [V_W-1:0] SAT_MAX = V_W'(32767);
   localparam logic signed [V_W-1:0] SAT_MIN = -V_W'(32768);

   // Register reset values: identity matrix, zero offsets
   localparam logic [ROW_W-1:0] ROW_X_RESET = 48'd16384;
   localparam logic [ROW_W-1:0] ROW_Y_RESET = 48'd1073741824;
   localparam logic [ROW_W-1:0] ROW_Z_RESET = 48'd70368744177664;

   // Configuration register indexes
   typedef enum logic [2:0] {
      CSR_HARD_X = 3'd0,
      CSR_HARD_Y = 3'd1,
      CSR_HARD_Z = 3'd2,
      CSR_ROW_X  = 3'd3,
      CSR_ROW_Y  = 3'd4,
      CSR_ROW_Z  = 3'd5
   } csr_index_type;

   // Channel payloads
   typedef struct packed {
      logic signed [AXIS_W-1:0] mag_x;
      logic signed [AXIS_W-1:0] mag_y;
      logic signed [AXIS_W-1:0] mag_z;
   } mag_in_type;

   typedef struct packed {
      logic signed [AXIS_W-1:0] cal_x;
      logic signed [AXIS_W-1:0] cal_y;
      logic signed [AXIS_W-1:0] cal_z;
      logic [HEAD_W-1:0]        heading;
   } cal_out_type;

   // Calibration registers; index 0 is x, 1 is y, 2 is z
   typedef struct packed {
      logic [2:0][AXIS_W-1:0] hard;
      logic [2:0][ROW_W-1:0]  row;
   } calib_type;

   // Data handed from cell to cell
   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [ANGLE_W-1:0] z;
      logic                      zero;
      logic signed [AXIS_W-1:0]  cal_x;
      logic signed [AXIS_W-1:0]  cal_y;
      logic signed [AXIS_W-1:0]  cal_z;
   } cord_type;

   // atan(2^-step) in 1/16384 degree
   function automatic logic signed [ANGLE_W-1:0] atan_angle(input int step);
      logic signed [ANGLE_W-1:0] a;
      case (step)
         0:       a = ANGLE_W'(737280);
         1:       a = ANGLE_W'(435242);
         2:       a = ANGLE_W'(229970);
         3:       a = ANGLE_W'(116736);
         4:       a = ANGLE_W'(58595);
         5:       a = ANGLE_W'(29326);
         6:       a = ANGLE_W'(14667);
         7:       a = ANGLE_W'(7334);
         8:       a = ANGLE_W'(3667);
         9:       a = ANGLE_W'(1833);
         10:      a = ANGLE_W'(917);
         11:      a = ANGLE_W'(458);
         12:      a = ANGLE_W'(229);
         13:      a = ANGLE_W'(115);
         14:      a = ANGLE_W'(57);
         15:      a = ANGLE_W'(29);
         16:      a = ANGLE_W'(14);
         17:      a = ANGLE_W'(7);
         18:      a = ANGLE_W'(4);
         19:      a = ANGLE_W'(2);
         20:      a = ANGLE_W'(1);
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

// ===== sv/compass_heading_calibrated_top.sv =====
`timescale 1ns / 1ps

// Channel   Ports                                   Direction  Transfer when
// req       req_valid req_ready req_data            in         req_valid & req_ready
// rsp       rsp_valid rsp_ready rsp_data            out        rsp_valid & rsp_ready
// csr       csr_valid csr_ready csr_index csr_data  in         csr_valid & csr_ready
//
// One sample per cycle while the skid register is empty. A sample passes from transfer to rsp_valid
// through four front stages, one cell per CORDIC step and the output register.
// Reset clears all valids and loads identity rows and zero offsets.
// The whole pipe moves on one enable; an output skid register takes one result while
// rsp is stalled, and req_ready drops only while that skid register is full.
// csr_ready is always high; indexes above 5 are ignored.

module compass_heading_calibrated_top import chc_pkg::*; #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  mag_in_type          req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output cal_out_type         rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [2:0]          csr_index,
   input  logic [ROW_W-1:0]    csr_data
);

   localparam int STEPS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;

   calib_type   cfg_ff;
   calib_type   cfg_in;

   logic        enable;
   logic        cell_valid [STEPS+1];
   cord_type    cell_data  [STEPS+1];

   cal_out_type result;
   logic signed [ANGLE_W-1:0] h_wide;
   logic [22:0]               h_round;
   logic [HEAD_W-1:0]         h_units;

   logic        out_valid_ff, out_valid_in;
   cal_out_type out_ff, out_in;
   logic        skid_valid_ff, skid_valid_in;
   cal_out_type skid_ff, skid_in;

   // Register writes
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_HARD_X: cfg_in.hard[0] = csr_data[AXIS_W-1:0];
            CSR_HARD_Y: cfg_in.hard[1] = csr_data[AXIS_W-1:0];
            CSR_HARD_Z: cfg_in.hard[2] = csr_data[AXIS_W-1:0];
            CSR_ROW_X:  cfg_in.row[0]  = csr_data;
            CSR_ROW_Y:  cfg_in.row[1]  = csr_data;
            CSR_ROW_Z:  cfg_in.row[2]  = csr_data;
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hard   <= '0;
         cfg_ff.row[0] <= ROW_X_RESET;
         cfg_ff.row[1] <= ROW_Y_RESET;
         cfg_ff.row[2] <= ROW_Z_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Pipe advances whenever the skid register is free
   assign enable    = !skid_valid_ff;
   assign req_ready = enable;

   chc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (req_valid && req_ready),
      .in_data   (req_data),
      .cfg       (cfg_ff),
      .out_valid (cell_valid[0]),
      .out_data  (cell_data[0])
   );

   // Row of CORDIC cells
   for (genvar k = 0; k < STEPS; k++) begin : g_cell
      chc_cordic_cell #(.STEP(k)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .in_valid  (cell_valid[k]),
         .in_data   (cell_data[k]),
         .out_valid (cell_valid[k+1]),
         .out_data  (cell_data[k+1])
      );
   end

   // Heading: negate angle, wrap into one turn, round to 1/64 degree
   always_comb begin
      if (cell_data[STEPS].z > 0) begin
         h_wide = ANGLE_FULL - cell_data[STEPS].z;
      end else begin
         h_wide = -cell_data[STEPS].z;
      end
      h_round = h_wide[22:0] + HEAD_ROUND;
      h_units = h_round[22:8];
      result.cal_x = cell_data[STEPS].cal_x;
      result.cal_y = cell_data[STEPS].cal_y;
      result.cal_z = cell_data[STEPS].cal_z;
      if (cell_data[STEPS].zero || h_units == HEAD_WRAP) begin
         result.heading = '0;
      end else begin
         result.heading = h_units;
      end
   end

   // Output register with skid stage
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (rsp_ready || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else if (enable && cell_valid[STEPS]) begin
            out_in       = result;
            out_valid_in = 1'b1;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (enable && cell_valid[STEPS]) begin
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // Skid register only fills behind a held output
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register full while output register empty");

   // A parked result is not dropped while rsp is stalled
   a_skid_kept: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && !rsp_ready |=> skid_valid_ff)
      else $error("skid result lost during stall");

   // Heading stays within one turn
   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.heading < HEAD_WRAP)
      else $error("heading out of range");

endmodule

// ===== sv/chc_front.sv =====
`timescale 1ns / 1ps

module chc_front import chc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       enable,
   input  logic       in_valid,
   input  mag_in_type in_data,
   input  calib_type  cfg,
   output logic       out_valid,
   output cord_type   out_data
);

   logic                     d_valid_ff;
   logic signed [DIFF_W-1:0] d_ff [3];
   logic signed [DIFF_W-1:0] d_in [3];

   logic                     p_valid_ff;
   logic signed [PROD_W-1:0] prod_ff [3][3];
   logic signed [PROD_W-1:0] prod_in [3][3];

   logic                     v_valid_ff;
   logic signed [V_W-1:0]    v_ff [3];
   logic signed [V_W-1:0]    v_in [3];
   logic signed [ACC_W-1:0]  acc [3];

   logic                     c_valid_ff;
   cord_type                 cord_ff;
   cord_type                 cord_in;
   logic signed [AXIS_W-1:0] sat [3];

   // Hard-iron subtraction
   assign d_in[0] = DIFF_W'(in_data.mag_x) - DIFF_W'(signed'(cfg.hard[0]));
   assign d_in[1] = DIFF_W'(in_data.mag_y) - DIFF_W'(signed'(cfg.hard[1]));
   assign d_in[2] = DIFF_W'(in_data.mag_z) - DIFF_W'(signed'(cfg.hard[2]));

   // Soft-iron products: row r, column c
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            prod_in[r][c] = PROD_W'(signed'(cfg.row[r][AXIS_W*c +: AXIS_W])) *
                            PROD_W'(d_ff[c]);
         end
      end
   end

   // Row sums, round half up to integer units
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         acc[r] = ACC_W'(prod_ff[r][0]) + ACC_W'(prod_ff[r][1]) +
                  ACC_W'(prod_ff[r][2]) + ROUND_HALF;
         v_in[r] = V_W'(acc[r] >>> FRAC_W);
      end
   end

   // Saturation and CORDIC start: fold the left half-plane onto the right
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         if (v_ff[a] > SAT_MAX) begin
            sat[a] = SAT_MAX[AXIS_W-1:0];
         end else if (v_ff[a] < SAT_MIN) begin
            sat[a] = SAT_MIN[AXIS_W-1:0];
         end else begin
            sat[a] = v_ff[a][AXIS_W-1:0];
         end
      end
      cord_in.cal_x = sat[0];
      cord_in.cal_y = sat[1];
      cord_in.cal_z = sat[2];
      cord_in.zero  = (v_ff[0] == '0) && (v_ff[1] == '0);
      if (v_ff[1] < 0) begin
         cord_in.x = -COORD_W'(v_ff[1]);
         cord_in.y = -COORD_W'(v_ff[0]);
         cord_in.z = ANGLE_HALF;
      end else begin
         cord_in.x = COORD_W'(v_ff[1]);
         cord_in.y = COORD_W'(v_ff[0]);
         cord_in.z = '0;
      end
   end

   // Stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
         p_valid_ff <= 1'b0;
         v_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (enable) begin
         d_valid_ff <= in_valid;
         p_valid_ff <= d_valid_ff;
         v_valid_ff <= p_valid_ff;
         c_valid_ff <= v_valid_ff;
      end
   end

   // Stage payloads
   always_ff @(posedge clock) begin
      if (enable) begin
         d_ff    <= d_in;
         prod_ff <= prod_in;
         v_ff    <= v_in;
         cord_ff <= cord_in;
      end
   end

   assign out_valid = c_valid_ff;
   assign out_data  = cord_ff;

endmodule

// ===== sv/chc_cordic_cell.sv =====
`timescale 1ns / 1ps

module chc_cordic_cell import chc_pkg::*; #(
   parameter int STEP = 0
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     enable,
   input  logic     in_valid,
   input  cord_type in_data,
   output logic     out_valid,
   output cord_type out_data
);

   localparam logic signed [ANGLE_W-1:0] ATAN = atan_angle(STEP);

   logic                      valid_ff;
   cord_type                  data_ff;
   cord_type                  data_in;
   logic signed [COORD_W-1:0] xs;
   logic signed [COORD_W-1:0] ys;

   // One vectoring rotation; zero ordinate counts as non-positive
   always_comb begin
      xs = in_data.x >>> STEP;
      ys = in_data.y >>> STEP;
      data_in = in_data;
      if (in_data.y > 0) begin
         data_in.x = in_data.x + ys;
         data_in.y = in_data.y - xs;
         data_in.z = in_data.z + ATAN;
      end else begin
         data_in.x = in_data.x - ys;
         data_in.y = in_data.y + xs;
         data_in.z = in_data.z - ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== verif/compass_heading_calibrated_tb.sv =====
`timescale 1ns / 1ps

module testbench;
   import chc_pkg::*;

   localparam int CORDIC_STEPS    = 16;
   localparam int PIPE_LATENCY    = 5 + CORDIC_STEPS;
   localparam int HOLD_OFF_CYCLES = 200;
   localparam int CYCLE_LIMIT     = 100000;

   // Angle bookkeeping in 1/16384 degree; heading wrap in 1/64 degree and the product rounding bias
   localparam longint FULL_TURN    = 5898240;
   localparam longint HALF_TURN    = 2949120;
   localparam longint HEADING_WRAP = 23040;
   localparam longint ROUND_BIAS   = 8192;

   // Indexes past the last register; writes there must be dropped
   localparam logic [2:0] CSR_SPARE_6 = 3'd6;
   localparam logic [2:0] CSR_SPARE_7 = 3'd7;

   typedef enum int {
      READY_ALWAYS,
      READY_RANDOM,
      READY_PERIODIC,
      READY_SPARSE
   } ready_pattern_type;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   mag_in_type        req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   cal_out_type       rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [2:0]        csr_index = '0;
   logic [ROW_W-1:0]  csr_data  = '0;

   // Shadow copy of the calibration registers
   logic [15:0]      hard_ofs [3] = '{16'd0, 16'd0, 16'd0};
   logic [ROW_W-1:0] soft_rows [3] = '{ROW_X_RESET, ROW_Y_RESET, ROW_Z_RESET};

   // atan(2^-i), 1/16384 degree
   longint arc_table [0:23] = '{
      737280, 435242, 229970, 116736, 58595, 29326, 14667, 7334,
      3667, 1833, 917, 458, 229, 115, 57, 29,
      14, 7, 4, 2, 1, 0, 0, 0
   };

   cal_out_type expected_cal_q [$];
   int          error_count = 0;
   int          cycle_count = 0;
   int          burst_left = 0;
   bit          steady_sender = 1'b0;
   bit          hold_off_request = 1'b0;

   compass_heading_calibrated_top #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #1 clock = ~clock;

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic logic signed [15:0] saturate_axis(longint v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return 16'(v);
   endfunction

   // Vectoring CORDIC on (vy, vx), heading = -angle wrapped to [0,360) in 1/64 deg
   function automatic logic [14:0] compass_heading(longint vx, longint vy);
      longint xa, yb, ang, xs, ys, h;
      int     steps;
      if (vx == 0 && vy == 0) return '0;
      xa = vy;
      yb = vx;
      ang = 0;
      // left half-plane: rotate by 180 first
      if (xa < 0) begin
         xa = -xa;
         yb = -yb;
         ang = HALF_TURN;
      end
      steps = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
      for (int i = 0; i < steps; i++) begin
         xs = xa >>> i;
         ys = yb >>> i;
         if (yb > 0) begin
            xa = xa + ys;
            yb = yb - xs;
            ang = ang + arc_table[i];
         end else begin
            xa = xa - ys;
            yb = yb + xs;
            ang = ang - arc_table[i];
         end
      end
      h = -ang;
      while (h < 0) h = h + FULL_TURN;
      while (h >= FULL_TURN) h = h - FULL_TURN;
      h = (h + 128) / 256;
      if (h >= HEADING_WRAP) h = 0;
      return 15'(h);
   endfunction

   // Offset removal, soft-iron matrix, rounding, saturation and heading
   function automatic cal_out_type predict_calibration(mag_in_type s);
      longint      d [3];
      longint      v [3];
      longint      acc;
      cal_out_type r;
      d[0] = longint'($signed(s.mag_x)) - longint'($signed(hard_ofs[0]));
      d[1] = longint'($signed(s.mag_y)) - longint'($signed(hard_ofs[1]));
      d[2] = longint'($signed(s.mag_z)) - longint'($signed(hard_ofs[2]));
      for (int r_i = 0; r_i < 3; r_i++) begin
         acc = 0;
         for (int k = 0; k < 3; k++)
            acc = acc + longint'($signed(soft_rows[r_i][16*k +: 16])) * d[k];
         v[r_i] = (acc + ROUND_BIAS) >>> 14;
      end
      r.cal_x   = saturate_axis(v[0]);
      r.cal_y   = saturate_axis(v[1]);
      r.cal_z   = saturate_axis(v[2]);
      r.heading = compass_heading(v[0], v[1]);
      return r;
   endfunction

   function automatic mag_in_type make_sample(int x, int y, int z);
      mag_in_type s;
      s.mag_x = 16'(x);
      s.mag_y = 16'(y);
      s.mag_z = 16'(z);
      return s;
   endfunction

   function automatic logic [15:0] corner_word();
      case ($urandom_range(0, 4))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'h0000;
         3:       return 16'h0001;
         default: return 16'hFFFF;
      endcase
   endfunction

   function automatic logic [15:0] near_word(longint base, int spread);
      return 16'(base + longint'($urandom_range(0, 2 * spread)) - spread);
   endfunction

   // Mostly full-range samples, some near the offsets (zero vector), some corners
   function automatic mag_in_type random_sample();
      mag_in_type s;
      int         pick;
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
         s.mag_x = 16'($urandom);
         s.mag_y = 16'($urandom);
         s.mag_z = 16'($urandom);
      end else if (pick < 8) begin
         s.mag_x = near_word(longint'($signed(hard_ofs[0])), 3);
         s.mag_y = near_word(longint'($signed(hard_ofs[1])), 3);
         s.mag_z = near_word(longint'($signed(hard_ofs[2])), 3);
      end else begin
         s.mag_x = corner_word();
         s.mag_y = corner_word();
         s.mag_z = corner_word();
      end
      return s;
   endfunction

   // One sample transfer; sender may idle between bursts unless held steady
   task automatic send_sample(mag_in_type s);
      int gap;
      if (!steady_sender && burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         burst_left = $urandom_range(1, 32);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      if (burst_left > 0) burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= s;
      do @(posedge clock); while (!req_ready);
      expected_cal_q.push_back(predict_calibration(s));
   endtask

   // Drop valid and wait until every outstanding result has come back
   task automatic drain_pipeline();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_cal_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(logic [2:0] idx, logic [ROW_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_HARD_X: hard_ofs[0] = value[15:0];
         CSR_HARD_Y: hard_ofs[1] = value[15:0];
         CSR_HARD_Z: hard_ofs[2] = value[15:0];
         CSR_ROW_X:  soft_rows[0] = value;
         CSR_ROW_Y:  soft_rows[1] = value;
         CSR_ROW_Z:  soft_rows[2] = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Offsets go out with junk in the upper data bits, which must be ignored
   task automatic load_calibration(logic [15:0] ofs [3], logic [ROW_W-1:0] rows [3]);
      write_register(CSR_HARD_X, {32'($urandom), ofs[0]});
      write_register(CSR_HARD_Y, {32'($urandom), ofs[1]});
      write_register(CSR_HARD_Z, {32'($urandom), ofs[2]});
      write_register(CSR_ROW_X, rows[0]);
      write_register(CSR_ROW_Y, rows[1]);
      write_register(CSR_ROW_Z, rows[2]);
   endtask

   // Identity matrix after reset: corners, axes, half-planes, wrap at 360
   task automatic test_reset_defaults();
      send_sample(make_sample(0, 0, 0));
      send_sample(make_sample(32767, 32767, 32767));
      send_sample(make_sample(-32768, -32768, -32768));
      send_sample(make_sample(32767, -32768, 0));
      send_sample(make_sample(-32768, 32767, -1));
      send_sample(make_sample(0, 100, 5));
      send_sample(make_sample(100, 0, -5));
      send_sample(make_sample(0, -100, 7));
      send_sample(make_sample(-100, 0, 9));
      send_sample(make_sample(100, -100, 0));
      send_sample(make_sample(-100, -100, 0));
      send_sample(make_sample(1, 0, 0));
      send_sample(make_sample(0, 1, 0));
      send_sample(make_sample(-1, 0, 0));
      send_sample(make_sample(0, -1, 0));
      send_sample(make_sample(1, 32767, 0));
      send_sample(make_sample(2, 32767, 0));
      send_sample(make_sample(-1, 32767, 0));
      drain_pipeline();
   endtask

   // Writes past the last register leave the calibration alone
   task automatic test_ignored_index();
      write_register(CSR_SPARE_6, '1);
      write_register(CSR_SPARE_7, {16'($urandom), 32'($urandom)});
      send_sample(make_sample(1234, -4321, 77));
      send_sample(make_sample(-32768, 0, 32767));
      send_sample(make_sample(5, 5, 5));
      drain_pipeline();
   endtask

   // Half-valued coefficients land exactly on the rounding midpoint
   task automatic test_half_rounding();
      logic [15:0]      ofs [3];
      logic [ROW_W-1:0] rows [3];
      ofs = '{16'd0, 16'd0, 16'd0};
      rows[0] = {16'h0000, 16'h0000, 16'h2000};
      rows[1] = {16'h0000, 16'h2000, 16'h0000};
      rows[2] = {16'hE000, 16'h0000, 16'h0000};
      load_calibration(ofs, rows);
      send_sample(make_sample(1, 1, 1));
      send_sample(make_sample(-1, -1, -1));
      send_sample(make_sample(3, -3, 1));
      send_sample(make_sample(-3, 3, -1));
      drain_pipeline();
   endtask

   // Receiver holds off while the sender streams, so the input must stall
   task automatic test_back_pressure();
      steady_sender = 1'b1;
      hold_off_request = 1'b1;
      repeat (90) send_sample(random_sample());
      steady_sender = 1'b0;
      drain_pipeline();
   endtask

   // Several calibrations, random samples under each
   task automatic test_random_calibration();
      logic [15:0]      ofs [3];
      logic [ROW_W-1:0] rows [3];
      int               count;
      for (int phase = 0; phase < 6; phase++) begin
         for (int r = 0; r < 3; r++) begin
            case (phase)
               0: begin
                  ofs[r]  = 16'($urandom);
                  rows[r] = {16'($urandom), 16'($urandom), 16'($urandom)};
               end
               1: begin
                  ofs[r] = near_word(0, 3000);
                  for (int k = 0; k < 3; k++)
                     rows[r][16*k +: 16] = (k == r) ? near_word(16384, 2000)
                                                    : near_word(0, 1500);
               end
               2: begin
                  ofs[r]  = 16'h8000;
                  rows[r] = {3{16'h8000}};
               end
               3: begin
                  ofs[r]  = 16'h7FFF;
                  rows[r] = {3{16'h7FFF}};
               end
               4: begin
                  ofs[r]  = corner_word();
                  rows[r] = {corner_word(), corner_word(), corner_word()};
               end
               default: begin
                  ofs[r]  = 16'($urandom);
                  rows[r] = '0;
               end
            endcase
         end
         case (phase)
            0, 4:    count = 80;
            1:       count = 100;
            2, 3:    count = 40;
            default: count = 15;
         endcase
         load_calibration(ofs, rows);
         repeat (count) send_sample(random_sample());
         drain_pipeline();
      end
   endtask

   // Result receiver: one long hold-off on request, otherwise a shifting stall pattern
   initial begin : rsp_stall_driver
      ready_pattern_type pattern;
      int                pattern_left;
      int                tick;
      bit                hold_done;
      pattern = READY_ALWAYS;
      pattern_left = 0;
      tick = 0;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request && !hold_done) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) @(negedge clock);
            hold_done = 1'b1;
         end else begin
            if (pattern_left == 0) begin
               pattern = ready_pattern_type'($urandom_range(0, 3));
               pattern_left = $urandom_range(20, 120);
            end
            pattern_left--;
            tick++;
            case (pattern)
               READY_ALWAYS:   rsp_ready <= 1'b1;
               READY_RANDOM:   rsp_ready <= ($urandom_range(0, 3) != 0);
               READY_PERIODIC: rsp_ready <= (tick % 5 == 0);
               default:        rsp_ready <= ($urandom_range(0, 9) < 3);
            endcase
         end
      end
   end

   // Compare each result transfer against the oldest prediction
   always @(posedge clock) begin : result_check
      cal_out_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_cal_q.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("unexpected result: cal (%0d, %0d, %0d) heading %0d",
                        rsp_data.cal_x, rsp_data.cal_y, rsp_data.cal_z, rsp_data.heading);
         end else begin
            want = expected_cal_q.pop_front();
            if (rsp_data.cal_x !== want.cal_x || rsp_data.cal_y !== want.cal_y ||
                rsp_data.cal_z !== want.cal_z || rsp_data.heading !== want.heading) begin
               error_count++;
               if (error_count <= 10)
                  $display({"mismatch: expected cal (%0d, %0d, %0d) heading %0d, ",
                            "got (%0d, %0d, %0d) heading %0d"},
                           want.cal_x, want.cal_y, want.cal_z, want.heading,
                           rsp_data.cal_x, rsp_data.cal_y, rsp_data.cal_z,
                           rsp_data.heading);
            end
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_ignored_index();
      test_half_rounding();
      test_back_pressure();
      test_random_calibration();
      repeat (PIPE_LATENCY + 10) @(posedge clock);
      if (error_count == 0 && expected_cal_q.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
